// ===== sv/tdlr_pkg.sv =====
// ----------------------------------------------------------------------------
// tdlr_pkg
// Shared types and constants of the thermal derate level ramp unit.
// ----------------------------------------------------------------------------
package tdlr_pkg;

  localparam int unsigned TempW  = 13;
  localparam int unsigned TimerW = 16;
  localparam int unsigned LimitW = 12;
  localparam int unsigned LevelW = 3;
  localparam int unsigned WarnW  = 2;
  localparam int unsigned IdxW   = 8;
  localparam int unsigned CfgDW  = 64;

  // register indexes
  localparam logic [IdxW-1:0] REG_START_TEMP       = 8'd0;
  localparam logic [IdxW-1:0] REG_END_TEMP         = 8'd1;
  localparam logic [IdxW-1:0] REG_LEVEL_TIMES      = 8'd2;
  localparam logic [IdxW-1:0] REG_HYSTERESIS_TIME  = 8'd3;
  localparam logic [IdxW-1:0] REG_CLEAR_TIME       = 8'd4;
  localparam logic [IdxW-1:0] REG_STALL_CLEAR_TIME = 8'd5;
  localparam logic [IdxW-1:0] REG_RAMP_STEP        = 8'd6;
  localparam logic [IdxW-1:0] REG_LEVEL_TARGETS    = 8'd7;

  // register reset values
  localparam logic signed [TempW-1:0] START_TEMP_RST = 13'sd1440;
  localparam logic signed [TempW-1:0] END_TEMP_RST   = 13'sd1280;
  localparam logic [TimerW-1:0] CLEAR_TIME_RST       = 16'd1000;
  localparam logic [TimerW-1:0] STALL_CLEAR_TIME_RST = 16'd1000;
  localparam logic [LimitW-1:0] RAMP_STEP_RST        = 12'd1;

  // derate levels
  localparam logic [LevelW-1:0] LVL_NORMAL = 3'd0;
  localparam logic [LevelW-1:0] LVL_ONE    = 3'd1;
  localparam logic [LevelW-1:0] LVL_TWO    = 3'd2;
  localparam logic [LevelW-1:0] LVL_THREE  = 3'd3;
  localparam logic [LevelW-1:0] LVL_FOUR   = 3'd4;
  localparam logic [LevelW-1:0] LVL_STALL  = 3'd5;

  // warning events
  localparam logic [WarnW-1:0] WARN_NONE  = 2'd0;
  localparam logic [WarnW-1:0] WARN_SET   = 2'd1;
  localparam logic [WarnW-1:0] WARN_CLEAR = 2'd2;

  typedef struct packed {
    logic signed [TempW-1:0] start_temp;
    logic signed [TempW-1:0] end_temp;
    logic [63:0]             level_times;
    logic [TimerW-1:0]       hysteresis_time;
    logic [TimerW-1:0]       clear_time;
    logic [TimerW-1:0]       stall_clear_time;
    logic [LimitW-1:0]       ramp_step;
    logic [59:0]             level_targets;
  } cfg_t;

  typedef struct packed {
    logic [LevelW-1:0] level;
    logic [TimerW-1:0] set_timer;
    logic [TimerW-1:0] clear_timer;
    logic [LimitW-1:0] target;
    logic [LimitW-1:0] ramp;
  } state_t;

  typedef struct packed {
    logic [WarnW-1:0]  warning_event;
    logic [LimitW-1:0] limit_ramped;
    logic [LimitW-1:0] limit_target;
    logic [LevelW-1:0] derate_level;
  } result_t;

  function automatic logic [TimerW-1:0] inc_sat(logic [TimerW-1:0] t,
                                                logic [TimerW-1:0] tmax);
    return (t >= tmax) ? tmax : t + 16'd1;
  endfunction

endpackage

// ===== sv/tdlr_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// tdlr_cfg_regs
// Configuration register file, written through a write enable, index and data.
// ----------------------------------------------------------------------------
module tdlr_cfg_regs import tdlr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  logic [IdxW-1:0]  wr_index_i,
  input  logic [CfgDW-1:0] wr_data_i,
  output cfg_t             cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (wr_index_i)
        REG_START_TEMP:       cfg_d.start_temp       = $signed(wr_data_i[TempW-1:0]);
        REG_END_TEMP:         cfg_d.end_temp         = $signed(wr_data_i[TempW-1:0]);
        REG_LEVEL_TIMES:      cfg_d.level_times      = wr_data_i;
        REG_HYSTERESIS_TIME:  cfg_d.hysteresis_time  = wr_data_i[TimerW-1:0];
        REG_CLEAR_TIME:       cfg_d.clear_time       = wr_data_i[TimerW-1:0];
        REG_STALL_CLEAR_TIME: cfg_d.stall_clear_time = wr_data_i[TimerW-1:0];
        REG_RAMP_STEP:        cfg_d.ramp_step        = wr_data_i[LimitW-1:0];
        REG_LEVEL_TARGETS:    cfg_d.level_targets    = wr_data_i[59:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_temp       <= START_TEMP_RST;
      cfg_q.end_temp         <= END_TEMP_RST;
      cfg_q.level_times      <= '0;
      cfg_q.hysteresis_time  <= '0;
      cfg_q.clear_time       <= CLEAR_TIME_RST;
      cfg_q.stall_clear_time <= STALL_CLEAR_TIME_RST;
      cfg_q.ramp_step        <= RAMP_STEP_RST;
      cfg_q.level_targets    <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== sv/tdlr_step.sv =====
// ----------------------------------------------------------------------------
// tdlr_step
// Next-state and result logic for one temperature tick.
// ----------------------------------------------------------------------------
module tdlr_step import tdlr_pkg::*; #(
  parameter int unsigned FULL_SCALE = 4095,
  parameter int unsigned TIMER_MAX  = 65535
) (
  input  cfg_t                    cfg_i,
  input  state_t                  state_i,
  input  logic signed [TempW-1:0] temp_i,
  input  logic                    stall_i,
  output state_t                  state_o,
  output result_t                 result_o
);

  localparam logic [TimerW-1:0] TmaxC = TimerW'(TIMER_MAX);
  localparam logic [LimitW-1:0] FullC = LimitW'(FULL_SCALE);

  logic [TimerW-1:0] th1, th2, th3, th4;
  logic signed [17:0] t_s, ub1, ub2, ub3;
  logic [TimerW-1:0] need;
  logic [LimitW-1:0] diff;
  logic [WarnW-1:0]  ev;
  state_t nxt;

  assign th1 = cfg_i.level_times[15:0];
  assign th2 = cfg_i.level_times[31:16];
  assign th3 = cfg_i.level_times[47:32];
  assign th4 = cfg_i.level_times[63:48];
  assign ub1 = $signed({2'b00, th2}) - $signed({2'b00, cfg_i.hysteresis_time});
  assign ub2 = $signed({2'b00, th3}) - $signed({2'b00, cfg_i.hysteresis_time});
  assign ub3 = $signed({2'b00, th4}) - $signed({2'b00, cfg_i.hysteresis_time});

  always_comb begin
    nxt  = state_i;
    ev   = WARN_NONE;
    need = '0;
    diff = '0;
    t_s  = '0;
    if (stall_i) begin
      nxt.target = cfg_i.level_targets[59:48];
      nxt.level  = LVL_STALL;
    end else if (temp_i >= cfg_i.start_temp) begin
      nxt.set_timer   = inc_sat(state_i.set_timer, TmaxC);
      nxt.clear_timer = '0;
      t_s = $signed({2'b00, nxt.set_timer});
      if (t_s >= $signed({2'b00, th1}) && t_s < ub1) begin
        nxt.target = cfg_i.level_targets[11:0];
        nxt.level  = LVL_ONE;
      end else if (t_s >= $signed({2'b00, th2}) && t_s < ub2) begin
        nxt.target = cfg_i.level_targets[23:12];
        nxt.level  = LVL_TWO;
      end else if (t_s >= $signed({2'b00, th3}) && t_s < ub3) begin
        nxt.target = cfg_i.level_targets[35:24];
        nxt.level  = LVL_THREE;
      end else if (nxt.set_timer >= th4) begin
        nxt.set_timer = th4;
        nxt.target    = cfg_i.level_targets[47:36];
        nxt.level     = LVL_FOUR;
      end
    end else if (state_i.set_timer != '0) begin
      nxt.set_timer = state_i.set_timer - 16'd1;
    end

    if (nxt.level != LVL_NORMAL && temp_i < cfg_i.end_temp && !stall_i) begin
      need = (nxt.level < LVL_STALL) ? cfg_i.clear_time : cfg_i.stall_clear_time;
      nxt.clear_timer = inc_sat(nxt.clear_timer, TmaxC);
      nxt.set_timer   = '0;
      if (nxt.clear_timer >= need) begin
        nxt.clear_timer = '0;
        nxt.target      = FullC;
        nxt.level       = LVL_NORMAL;
      end
    end

    if (state_i.level != nxt.level) begin
      ev = (nxt.level == LVL_NORMAL) ? WARN_CLEAR : WARN_SET;
    end

    if (state_i.ramp > nxt.target) begin
      diff = state_i.ramp - nxt.target;
      nxt.ramp = (diff <= cfg_i.ramp_step) ? nxt.target : state_i.ramp - cfg_i.ramp_step;
    end else if (state_i.ramp < nxt.target) begin
      diff = nxt.target - state_i.ramp;
      nxt.ramp = (diff <= cfg_i.ramp_step) ? nxt.target : state_i.ramp + cfg_i.ramp_step;
    end
  end

  assign state_o                = nxt;
  assign result_o.derate_level  = nxt.level;
  assign result_o.limit_target  = nxt.target;
  assign result_o.limit_ramped  = nxt.ramp;
  assign result_o.warning_event = ev;

endmodule

// ===== sv/thermal_derate_level_ramp_unit.sv =====
// ----------------------------------------------------------------------------
// thermal_derate_level_ramp_unit
// Thermal and stall derate level controller with ramped current limit.
// ----------------------------------------------------------------------------
// One input word per control tick: s_axis_tdata carries the motor temperature
// (signed, 1/16 degC), s_axis_tuser carries stall_active. Each accepted word
// yields exactly one output word on m_axis with derate_level, limit_target,
// limit_ramped and warning_event.
// The word is captured in an input register, then the tick logic updates the
// state registers and loads the output register.
// Throughput is one word per cycle while the receiver takes words; the input
// register advances whenever the output register is empty or being taken, so
// the state update is the only loop.
// When the receiver stalls, the output word holds and one more word may wait
// in the input register; s_axis_tready then drops.
// Configuration registers are written on the cfg channel (always ready) and
// should change only while no word is in flight.
// Reset clears both pipeline registers, sets the level to normal, both timers
// to zero, target and ramped limit to full scale, registers to their defaults.
// ----------------------------------------------------------------------------
module thermal_derate_level_ramp_unit import tdlr_pkg::*; #(
  parameter int unsigned FULL_SCALE = 4095,
  parameter int unsigned TIMER_MAX  = 65535
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [15:0]      s_axis_tdata,   // [12:0] temp_sample
  input  logic [0:0]       s_axis_tuser,   // [0] stall_active
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [2:0] derate_level, [14:3] limit_target,
                                           // [26:15] limit_ramped, [28:27] warning_event
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [IdxW-1:0]  cfg_index_i,
  input  logic [CfgDW-1:0] cfg_data_i
);

  cfg_t    cfg;
  state_t  state_q, state_d;
  result_t res_d, res_q;

  logic                    in_valid_q;
  logic signed [TempW-1:0] temp_q;
  logic                    stall_q;
  logic                    out_valid_q;
  logic                    out_load, step_fire, in_load;

  assign cfg_ready_o = 1'b1;

  tdlr_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  tdlr_step #(
    .FULL_SCALE (FULL_SCALE),
    .TIMER_MAX  (TIMER_MAX)
  ) u_step (
    .cfg_i    (cfg),
    .state_i  (state_q),
    .temp_i   (temp_q),
    .stall_i  (stall_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  assign out_load      = !out_valid_q || m_axis_tready;
  assign step_fire     = in_valid_q && out_load;
  assign s_axis_tready = !in_valid_q || out_load;
  assign in_load       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      temp_q  <= $signed(s_axis_tdata[TempW-1:0]);
      stall_q <= s_axis_tuser[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.level       <= LVL_NORMAL;
      state_q.set_timer   <= '0;
      state_q.clear_timer <= '0;
      state_q.target      <= LimitW'(FULL_SCALE);
      state_q.ramp        <= LimitW'(FULL_SCALE);
    end else if (step_fire) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_fire) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, res_q};

`ifndef SYNTHESIS
  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.level <= LVL_STALL)
    else $error("derate level out of range");

  a_normal_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.level == LVL_NORMAL |-> state_q.target == LimitW'(FULL_SCALE))
    else $error("normal level without full scale target");

  a_warn_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_fire |=> ((res_q.warning_event != WARN_NONE) ==
                   (state_q.level != $past(state_q.level))))
    else $error("warning event does not match level change");

  a_ready_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_valid_q && out_valid_q && !m_axis_tready))
    else $error("input stalled without a full pipeline");
`endif

endmodule
